FILE: rtl/hdf_pkg.sv
// ----------------------------------------------------------------------------
// hdf_pkg : shared types for the 1D heat diffusion solver
// Command and result words, op codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package hdf_pkg;

  localparam int unsigned ValW   = 24;  // temperature, signed Q2.21
  localparam int unsigned CoeffW = 16;  // diffusion coefficient, unsigned Q0.16
  localparam int unsigned IdxW   = 7;   // cell index field
  localparam int unsigned StepW  = 16;  // step count field
  localparam int unsigned CfgIdxW = 2;  // configuration register index

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam logic [CfgIdxW-1:0] CFG_COEFF = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAST  = 2'd1;

  localparam logic [CoeffW-1:0] CoeffReset = 16'd328;
  localparam logic [IdxW-1:0]   LastReset  = 7'd100;

  typedef struct packed {
    op_e                     op;
    logic [IdxW-1:0]         cell_index;
    logic signed [ValW-1:0]  cell_value;
    logic [StepW-1:0]        step_count;
  } cmd_t;

  typedef struct packed {
    logic signed [ValW-1:0]  read_value;
    logic                    done_res;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,    // wait for a command word
    S_READ,    // read data returning from the grid
    S_STEP,    // open a time step: fetch the left boundary
    S_LEFT,    // capture the left boundary, fetch cell 1
    S_CENTRE,  // capture cell 1, fetch cell 2
    S_MUL,     // form the Laplacian and multiply by the coefficient
    S_UPD      // round, add, saturate and write back one cell
  } state_e;

endpackage

FILE: rtl/heat_diffusion_ftcs_1d.sv
// ----------------------------------------------------------------------------
// heat_diffusion_ftcs_1d : explicit FTCS solver for the 1D heat equation
// Grid in on-chip memory, one multiply-round-saturate unit shared by all cells.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a word on cmd_i is taken at a rising edge with start_i
//   high and busy_o low. Ops: load a cell, run step_count time steps, read a
//   cell. Any other op completes with done_res low.
//   Result channel: every command gives exactly one result word on res_o,
//   marked by res_valid_o for one cycle. The receiver cannot stall it.
//   Config channel: cfg_valid_i/cfg_ready_o with index and data; index 0 is
//   the coefficient (Q0.16), index 1 the right boundary cell. Write it only
//   while the block is idle; cfg_ready_o is always high.
// Sequence (command taken to strobe)
//   load, unknown op, idle run: the strobe is registered; busy_o never rises.
//   read: S_READ, then the registered strobe.
//   run:  step_count time steps over cells 1 to R-1, R the clamped boundary cell.
//   Each interior cell goes through the single grid read port and the one
//   multiplier: multiply in S_MUL, then round/add/saturate/write in S_UPD.
// Reset clears the sequencer and restores the registers to their defaults;
// grid contents are undefined until loaded.
module heat_diffusion_ftcs_1d #(
  parameter int unsigned CELLS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  hdf_pkg::cmd_t                     cmd_i,
  output logic                              res_valid_o,
  output hdf_pkg::res_t                     res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hdf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hdf_pkg::CoeffW-1:0]        cfg_data_i
);
  import hdf_pkg::*;

  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned IW = (AW > IdxW) ? AW : IdxW;
  localparam int unsigned LapW  = ValW + 3;
  localparam int unsigned ProdW = LapW + CoeffW + 1;
  localparam int unsigned RndW  = ProdW - 16;
  localparam int unsigned SumW  = RndW + 1;

  // Grid memory
  logic [ValW-1:0] mem [CELLS];
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [ValW-1:0] mem_wdata;
  logic [ValW-1:0] rd_data_q;

  // Control
  state_e           state_q, state_d;
  logic [StepW-1:0] steps_q;
  logic [CoeffW-1:0] coeff_q;
  logic [IdxW-1:0]  last_q;
  logic             res_valid_q;
  res_t             res_q;
  logic             rd_oob_q;
  logic             res_fire;

  // Datapath
  logic [AW-1:0]           idx_q;
  logic signed [ValW-1:0]  left_q, centre_q;
  logic signed [ProdW-1:0] prod_q, prod_d;

  logic             cmd_take;
  logic [IW-1:0]    cmd_idx_w, last_w, right_w;
  logic [AW-1:0]    cmd_addr, right;
  logic             idx_ok, run_ok, cell_last;
  logic signed [LapW-1:0]  lap;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [RndW-1:0]  upd;
  logic signed [SumW-1:0]  sum;
  logic signed [ValW-1:0]  new_val;

  assign cmd_take  = start_i && !busy_o;
  assign cmd_idx_w = IW'(cmd_i.cell_index);
  assign cmd_addr  = cmd_idx_w[AW-1:0];
  assign idx_ok    = 32'(cmd_i.cell_index) < 32'(CELLS);

  // Clamp the right boundary to the last stored cell
  assign last_w  = IW'(last_q);
  assign right_w = (32'(last_w) > 32'(CELLS - 1)) ? IW'(CELLS - 1) : last_w;
  assign right   = right_w[AW-1:0];
  assign run_ok  = (cmd_i.step_count != '0) && (32'(right_w) >= 32'd2);
  assign cell_last = (idx_q + AW'(1)) == right;

  // Shared arithmetic: Laplacian times coefficient, then round half up
  assign lap = LapW'(left_q) - (LapW'(centre_q) <<< 1)
             + LapW'($signed(rd_data_q));
  assign prod_d   = ProdW'($signed({1'b0, coeff_q})) * ProdW'(lap);
  assign prod_rnd = prod_q + ProdW'(32768);
  assign upd      = prod_rnd[ProdW-1:16];
  assign sum      = SumW'(centre_q) + SumW'(upd);

  always_comb begin
    priority if (sum > SumW'(8388607)) begin
      new_val = ValW'(8388607);
    end else if (sum < -SumW'(8388608)) begin
      new_val = ValW'(-8388608);
    end else begin
      new_val = sum[ValW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (cmd_i.op == OP_READ) begin
            state_d = S_READ;
          end else if (cmd_i.op == OP_RUN && run_ok) begin
            state_d = S_STEP;
          end
        end
      end
      S_READ:   state_d = S_IDLE;
      S_STEP:   state_d = S_LEFT;
      S_LEFT:   state_d = S_CENTRE;
      S_CENTRE: state_d = S_MUL;
      S_MUL:    state_d = S_UPD;
      S_UPD: begin
        if (!cell_last) begin
          state_d = S_MUL;
        end else if (steps_q == StepW'(1)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_STEP;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd_addr;
    mem_wdata = cmd_i.cell_value;
    mem_re    = 1'b0;
    mem_raddr = cmd_addr;
    unique case (state_q)
      S_IDLE: begin
        mem_we = cmd_take && cmd_i.op == OP_LOAD && idx_ok;
        mem_re = cmd_take && cmd_i.op == OP_READ && idx_ok;
      end
      S_STEP: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_LEFT: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      S_CENTRE: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(2);
      end
      S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = new_val;
        mem_re    = !cell_last;
        mem_raddr = idx_q + AW'(2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // Strobe a result word: an immediate command, a read returning, or the
  // last cell of the last step
  assign res_fire = (state_q == S_IDLE && cmd_take && cmd_i.op != OP_READ
                     && !(cmd_i.op == OP_RUN && run_ok))
                 || (state_q == S_READ)
                 || (state_q == S_UPD && cell_last && steps_q == StepW'(1));

  // Sequencer, step counter, result strobe and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      steps_q     <= '0;
      res_valid_q <= 1'b0;
      coeff_q     <= CoeffReset;
      last_q      <= LastReset;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_fire;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_COEFF: coeff_q <= cfg_data_i;
          CFG_LAST:  last_q  <= cfg_data_i[IdxW-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == S_IDLE && cmd_take && cmd_i.op == OP_RUN && run_ok) begin
        steps_q <= cmd_i.step_count;
      end else if (state_q == S_UPD && cell_last) begin
        steps_q <= steps_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (state_q == S_LEFT) begin
      left_q <= $signed(rd_data_q);
    end else if (state_q == S_UPD) begin
      left_q <= centre_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rd_oob_q <= !idx_ok;
        res_q.read_value <= '0;
        res_q.done_res   <= cmd_i.op != OP_NONE;
      end
      S_READ: begin
        res_q.read_value <= rd_oob_q ? '0 : $signed(rd_data_q);
        res_q.done_res   <= 1'b1;
      end
      S_STEP: idx_q <= AW'(1);
      S_CENTRE: centre_q <= $signed(rd_data_q);
      S_MUL: prod_q <= prod_d;
      S_UPD: begin
        centre_q <= $signed(rd_data_q);
        idx_q    <= idx_q + AW'(1);
        res_q.read_value <= '0;
        res_q.done_res   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  // Checks
  a_upd_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (idx_q != '0 && idx_q < right))
    else $error("update outside the interior cells");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (steps_q != '0))
    else $error("time step opened with no steps left");

  a_busy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != S_IDLE) |-> (state_q == S_UPD))
    else $error("grid written outside the update state");

  a_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.done_res) |->
      $past(cmd_take && cmd_i.op == OP_NONE))
    else $error("done cleared without an unknown op");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the 1D FTCS heat diffusion solver
// Loads, runs and reads are driven into the block. A predictor keeps its own
// grid, coefficient and boundary cell, works out the result word for every
// accepted command, and each result word is compared with the oldest
// prediction. Directed tests cover the extremes first; random traffic follows
// under several register settings and sender gap patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hdf_pkg::*;

  localparam int unsigned Cells        = 128;
  localparam int unsigned PeriodNs     = 10;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned SettleCycles = 8;     // quiet cycles before a register write
  localparam int unsigned LimitCycles  = 6_000_000;
  localparam int unsigned PhaseItems   = 670;   // three phases, about 2000 words
  localparam int unsigned PrintCap     = 25;    // mismatch lines printed at most
  localparam longint      TempMax      = 64'sd8388607;
  localparam longint      TempMin      = -64'sd8388608;
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 2'd3;  // decodes to no register

  // DUT signals; the inputs are all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  cmd_t                cmd_i       = '0;
  logic                res_valid_o;
  res_t                res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CoeffW-1:0]   cfg_data_i  = '0;

  // predictor state
  logic signed [ValW-1:0] cell_temp [Cells];
  logic [CoeffW-1:0]      coeff_now;
  logic [IdxW-1:0]        right_cell;
  res_t                   expected_words [$];

  // book-keeping
  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned words_sent   = 0;
  int unsigned runs_sent    = 0;
  longint      steps_total  = 0;
  int unsigned words_seen   = 0;
  int unsigned gap_pct      = 0;
  res_t        want;

  heat_diffusion_ftcs_1d #(.CELLS(Cells)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(PeriodNs / 2.0) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One explicit time step over the interior cells. The sweep is in place, so
  // hold the old value of the left neighbour as the walk advances.
  function automatic void diffuse_step(int unsigned right);
    logic signed [ValW-1:0] left_prev;
    logic signed [ValW-1:0] centre;
    longint                 lap;
    longint                 upd;
    longint                 sum;
    left_prev = cell_temp[0];
    for (int unsigned i = 1; i < right; i++) begin
      centre = cell_temp[i];
      lap    = longint'(left_prev) - 2 * longint'(centre) + longint'(cell_temp[i + 1]);
      // Q0.16 times Q2.21, round half up back to Q2.21: add half, then floor
      upd    = (longint'(coeff_now) * lap + 64'sd32768) >>> 16;
      sum    = longint'(centre) + upd;
      if (sum > TempMax) sum = TempMax;
      else if (sum < TempMin) sum = TempMin;
      cell_temp[i] = sum[ValW-1:0];
      left_prev    = centre;
    end
  endfunction

  // Apply one accepted command word to the predicted state and return the
  // result word it must produce.
  function automatic res_t predict_word(cmd_t c);
    res_t        r;
    int unsigned right;
    r.read_value = '0;
    r.done_res   = 1'b1;
    case (c.op)
      OP_LOAD: begin
        cell_temp[c.cell_index] = c.cell_value;
      end
      OP_RUN: begin
        right = (right_cell > Cells - 1) ? Cells - 1 : right_cell;
        for (int unsigned s = 0; s < c.step_count; s++) begin
          if (right >= 2) diffuse_step(right);
        end
      end
      OP_READ: begin
        r.read_value = cell_temp[c.cell_index];
      end
      default: begin
        r.done_res = 1'b0;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: the receiver cannot stall, so take every strobed word
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= PrintCap)
      $display("cycle %0d: mismatch, %s", cycle_cnt, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch("result word with no command outstanding");
      end else begin
        want = expected_words.pop_front();
        if (res_o.read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %0d want %0d",
                                    res_o.read_value, want.read_value));
        if (res_o.done_res !== want.done_res)
          report_mismatch($sformatf("done_res got %0b want %0b",
                                    res_o.done_res, want.done_res));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic cmd_t make_cmd(op_e op, logic [IdxW-1:0] idx,
                                    logic [ValW-1:0] val, logic [StepW-1:0] cnt);
    cmd_t c;
    c.op         = op;
    c.cell_index = idx;
    c.cell_value = val;
    c.step_count = cnt;
    return c;
  endfunction

  // Present one command word and hold it until the block takes it. Leave
  // start high afterwards: the next word, a pause or a drain decides.
  task automatic send_word(input cmd_t c);
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    expected_words.push_back(predict_word(c));
    words_sent++;
    if (c.op == OP_RUN) begin
      runs_sent++;
      steps_total += c.step_count;
    end
  endtask

  // Random sender idling at the current gap rate.
  task automatic sender_pause();
    int unsigned n;
    if ($urandom_range(99) < gap_pct) begin
      n = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every outstanding word is back and the
  // block has settled.
  task automatic drain_words();
    start_i <= 1'b0;
    while (expected_words.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register; valid stays high so back-to-back writes need no
  // lowering in between. Close a batch with end_writes.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoeffW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COEFF: coeff_now  = data;
      CFG_LAST:  right_cell = data[IdxW-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [CoeffW-1:0] coeff, input logic [CoeffW-1:0] last);
    write_reg(CFG_COEFF, coeff);
    write_reg(CFG_LAST, last);
    end_writes();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill every cell so that no step and no read ever touches an unwritten one.
  task automatic test_preload();
    for (int unsigned i = 0; i < Cells; i++)
      send_word(make_cmd(OP_LOAD, IdxW'(i), ValW'($urandom()), StepW'($urandom())));
    drain_words();
  endtask

  // Field extremes, every op and short runs at the reset settings.
  task automatic test_extremes();
    send_word(make_cmd(OP_LOAD, 7'd0,   24'h7FFFFF, 16'h0000));
    send_word(make_cmd(OP_LOAD, 7'd127, 24'h800000, 16'hFFFF));
    send_word(make_cmd(OP_LOAD, 7'd1,   24'h000000, 16'h0000));
    send_word(make_cmd(OP_LOAD, 7'd64,  24'hFFFFFF, 16'h0000));
    send_word(make_cmd(OP_READ, 7'd0,   24'h000000, 16'h0000));
    send_word(make_cmd(OP_READ, 7'd127, 24'hFFFFFF, 16'hFFFF));
    send_word(make_cmd(OP_READ, 7'd1,   24'h000000, 16'h0000));
    send_word(make_cmd(OP_READ, 7'd64,  24'h000000, 16'h0000));
    // unknown op with every other field at its top: must change nothing
    send_word(make_cmd(OP_NONE, 7'd127, 24'h7FFFFF, 16'hFFFF));
    // zero steps completes at once
    send_word(make_cmd(OP_RUN,  7'd5,   24'h123456, 16'd0));
    send_word(make_cmd(OP_RUN,  7'd0,   24'h000000, 16'd1));
    send_word(make_cmd(OP_READ, 7'd1,   24'h000000, 16'h0000));
    send_word(make_cmd(OP_READ, 7'd99,  24'h000000, 16'h0000));
    send_word(make_cmd(OP_READ, 7'd100, 24'h000000, 16'h0000));
    send_word(make_cmd(OP_RUN,  7'd0,   24'h000000, 16'd2));
    send_word(make_cmd(OP_READ, 7'd2,   24'h000000, 16'h0000));
    drain_words();
  endtask

  // Coefficient and boundary extremes, saturation, and the long runs that
  // exercise the top bits of the step count on a tiny grid.
  task automatic test_settings_extremes();
    // zero coefficient over the widest grid: nothing may move
    set_regs(16'd0, 16'd127);
    send_word(make_cmd(OP_RUN,  7'd0,   24'h0, 16'd2));
    send_word(make_cmd(OP_READ, 7'd126, 24'h0, 16'h0));
    drain_words();

    // coefficient far above one half with a checkerboard: forces saturation
    set_regs(16'hFFFF, 16'd127);
    send_word(make_cmd(OP_LOAD, 7'd10, 24'h7FFFFF, 16'h0));
    send_word(make_cmd(OP_LOAD, 7'd11, 24'h800000, 16'h0));
    send_word(make_cmd(OP_LOAD, 7'd12, 24'h7FFFFF, 16'h0));
    send_word(make_cmd(OP_RUN,  7'd0,  24'h0,      16'd1));
    send_word(make_cmd(OP_READ, 7'd11, 24'h0,      16'h0));
    send_word(make_cmd(OP_READ, 7'd10, 24'h0,      16'h0));
    drain_words();

    // one interior cell, coefficient exactly one half, step count bit 15 set
    set_regs(16'd32768, 16'd2);
    send_word(make_cmd(OP_RUN,  7'd0, 24'h0, 16'h8000));
    send_word(make_cmd(OP_READ, 7'd1, 24'h0, 16'h0));
    drain_words();

    // no interior cell: upper data bits must be dropped, spare index ignored
    write_reg(CfgUnusedIdx, 16'hFFFF);
    write_reg(CFG_LAST, 16'hFF80);
    end_writes();
    send_word(make_cmd(OP_RUN,  7'd0, 24'h0, 16'h7FFF));
    send_word(make_cmd(OP_READ, 7'd1, 24'h0, 16'h0));
    drain_words();

    set_regs(16'd12345, 16'd1);
    send_word(make_cmd(OP_RUN,  7'd0, 24'h0, 16'd3));
    send_word(make_cmd(OP_READ, 7'd1, 24'h0, 16'h0));
    drain_words();
  endtask

  // Random traffic: mostly loads and reads around short runs, so the grid is
  // rewritten, diffused and read back in every shape. Runs stay short on
  // wide grids to keep the sweep time down.
  task automatic test_random_phase(input int unsigned pct, input logic [CoeffW-1:0] coeff,
                                   input logic [CoeffW-1:0] last);
    int unsigned pick;
    logic [StepW-1:0] cnt;
    set_regs(coeff, last);
    gap_pct = pct;
    for (int unsigned n = 0; n < PhaseItems; n++) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        send_word(make_cmd(OP_LOAD, IdxW'($urandom()), ValW'($urandom()), StepW'($urandom())));
      end else if (pick < 58) begin
        cnt = (right_cell <= 16) ? StepW'($urandom_range(0, 12)) : StepW'($urandom_range(0, 3));
        send_word(make_cmd(OP_RUN, IdxW'($urandom()), ValW'($urandom()), cnt));
      end else if (pick < 97) begin
        send_word(make_cmd(OP_READ, IdxW'($urandom()), ValW'($urandom()), StepW'($urandom())));
      end else begin
        send_word(make_cmd(OP_NONE, IdxW'($urandom()), ValW'($urandom()), StepW'($urandom())));
      end
      // now and then hold the sender until the block has caught up
      if (n % 200 == 199) drain_words();
      else sender_pause();
    end
    drain_words();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    for (int unsigned i = 0; i < Cells; i++) cell_temp[i] = '0;
    coeff_now  = CoeffReset;
    right_cell = LastReset;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preload();
    test_extremes();
    test_settings_extremes();
    test_random_phase(12, 16'($urandom_range(0, 32768)), 16'd127);
    test_random_phase(75, 16'd32768, 16'($urandom_range(2, 60)));
    test_random_phase(0,  16'hFFFF,  16'($urandom_range(2, 127)));

    $display("run covered %0d command words (%0d runs, %0d time steps), %0d results",
             words_sent, runs_sent, steps_total, words_seen);
    $display("coefficients from zero to full scale, boundary cells 0 to 127, %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("[heat_diffusion_ftcs_1d] OK");
    end else begin
      $display("[heat_diffusion_ftcs_1d] ERROR");
    end
    $finish;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    wait (cycle_cnt >= LimitCycles);
    $display("[heat_diffusion_ftcs_1d] ERROR");
    $finish;
  end

endmodule
